// ===== src/sltn_pkg.sv =====
// Shared constants, codes and types of the sorted line-number table.
package sltn_pkg;

  localparam int MAX_ENTRIES = 512;
  localparam int TAG_W       = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Fixed field widths at the ports.
  localparam int CMD_W  = 3;
  localparam int LN_W   = 16;
  localparam int KEY_W  = 15;
  localparam int PTAG_W = 16;
  localparam int POS_W  = 9;
  localparam int STAT_W = 3;
  localparam int OIDX_W = 9;
  localparam int OCNT_W = 10;

  // The selection reduce runs over groups of cells, then over the groups.
  localparam int GRP_SIZE = 32;
  localparam int NGRP     = (MAX_ENTRIES + GRP_SIZE - 1) / GRP_SIZE;

  localparam logic [CMD_W-1:0] CMD_STORE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_REPLACED = 3'd1;
  localparam logic [STAT_W-1:0] ST_DONE     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STAT_W-1:0] ST_INVALID  = 3'd5;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_DELETE,
    OP_REPLACE
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_SEL,
    S_RED,
    S_UPD
  } state_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic              cmp_en;
    logic              by_pos;
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  tag;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
    cell_op_t          op;
  } cell_ctl_t;

  // What a selected cell offers to the reduce; all zeros when not selected.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             hit;
  } sel_word_t;

endpackage

// ===== src/sltn_cell.sv =====
// One table slot: holds a key and tag, compares, and shifts with its neighbors.
module sltn_cell import sltn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [IDX_W-1:0]  index,
  input  cell_ctl_t         ctl,
  input  logic              prev_ge,
  input  logic [KEY_W-1:0]  prev_key,
  input  logic [TAG_W-1:0]  prev_tag,
  input  logic [KEY_W-1:0]  next_key,
  input  logic [TAG_W-1:0]  next_tag,
  output logic              ge,
  output logic [KEY_W-1:0]  key,
  output logic [TAG_W-1:0]  tag,
  output sel_word_t         sel_word
);

  logic eq;
  logic at_pos;
  logic occ;
  logic first;
  logic sel;

  assign occ = {{(CNT_W - IDX_W){1'b0}}, index} < ctl.count;

  // The table is sorted, so ge is a thermometer: the first set cell is the
  // match or the insertion point.
  assign first = ge & ~prev_ge;
  assign sel   = ctl.by_pos ? at_pos : first;

  always_comb begin
    sel_word.idx = sel ? index : '0;
    sel_word.key = sel ? key : '0;
    sel_word.tag = sel ? tag : '0;
    sel_word.hit = sel & eq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ge     <= 1'b0;
      eq     <= 1'b0;
      at_pos <= 1'b0;
    end else if (ctl.cmp_en) begin
      ge     <= ~occ | (key >= ctl.key);
      eq     <= occ & (key == ctl.key);
      at_pos <= occ & ({{(POS_W - IDX_W){1'b0}}, index} == ctl.pos);
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_INSERT: begin
        if (ge) begin
          key <= first ? ctl.key : prev_key;
          tag <= first ? ctl.tag : prev_tag;
        end
      end
      OP_DELETE: begin
        if (ge) begin
          key <= next_key;
          tag <= next_tag;
        end
      end
      OP_REPLACE: begin
        if (first) begin
          tag <= ctl.tag;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/sltn_group.sv =====
// Registered OR-reduce of the selection words of one group of cells.
module sltn_group import sltn_pkg::*; (
  input  logic                           clk,
  input  sel_word_t [GRP_SIZE-1:0]       words,
  output sel_word_t                      merged
);

  sel_word_t acc;

  // At most one cell in the whole row is selected, so OR acts as a mux.
  always_comb begin
    acc = '0;
    for (int i = 0; i < GRP_SIZE; i++) begin
      acc = sel_word_t'(acc | words[i]);
    end
  end

  always_ff @(posedge clk) begin
    merged <= acc;
  end

endmodule

// ===== src/sorted_line_number_table.sv =====
// Sorted line-number table: a row of cells kept in ascending key order, with
// one word taking five steps: capture, compare in every cell, select and
// reduce within groups, reduce across groups, then decide and shift the whole
// row by one slot at once. The compare-select-reduce path through the cell row
// and the two-level reduce tree set those steps. A new word is accepted while
// the previous result still waits at the output register. The table needs no
// clearing pass after reset; only slots below the entry count are ever read.
module sorted_line_number_table import sltn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] line, [31:16] payload_tag, [32] text_empty,
  // [41:33] position, [47:42] zero
  input  logic [47:0] s_axis_tdata,
  // [2:0] command
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [11:3] entry_index, [26:12] entry_line,
  // [42:27] entry_payload, [52:43] entry_count, [55:53] zero
  output logic [55:0] m_axis_tdata
);

  state_t state, state_next;

  // Captured command.
  logic [CMD_W-1:0] cmd;
  logic [LN_W-1:0]  ln;
  logic [TAG_W-1:0] ptag;
  logic             empty;
  logic [POS_W-1:0] pos;

  logic [CNT_W-1:0] count, count_next;
  sel_word_t        found;
  sel_word_t        top_acc;

  logic              out_valid;
  logic [STAT_W-1:0] out_status, out_status_next;
  logic [OIDX_W-1:0] out_index, out_index_next;
  logic [KEY_W-1:0]  out_line, out_line_next;
  logic [PTAG_W-1:0] out_tag, out_tag_next;
  logic [OCNT_W-1:0] out_count;

  cell_op_t  op;
  cell_ctl_t ctl;
  logic      fire;
  logic      ln_ok;
  logic      in_fire;

  logic      [MAX_ENTRIES-1:0] ge_row;
  logic      [KEY_W-1:0]       key_row [MAX_ENTRIES];
  logic      [TAG_W-1:0]       tag_row [MAX_ENTRIES];
  sel_word_t [NGRP*GRP_SIZE-1:0] sel_row;
  sel_word_t [NGRP-1:0]          grp_row;

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_count, out_tag, out_line, out_index, out_status};

  assign ln_ok = (ln != '0) && !ln[LN_W-1];
  assign fire  = (state == S_UPD) && (!out_valid || m_axis_tready);

  always_comb begin
    ctl.cmp_en = (state == S_CMP);
    ctl.by_pos = (cmd == CMD_READ);
    ctl.key    = ln[KEY_W-1:0];
    ctl.tag    = ptag;
    ctl.pos    = pos;
    ctl.count  = count;
    ctl.op     = fire ? op : OP_NONE;
  end

  // Cell row.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic             pge;
    logic [KEY_W-1:0] pkey, nkey;
    logic [TAG_W-1:0] ptg, ntg;
    if (i == 0) begin : g_head
      assign pge  = 1'b0;
      assign pkey = '0;
      assign ptg  = '0;
    end else begin : g_body
      assign pge  = ge_row[i-1];
      assign pkey = key_row[i-1];
      assign ptg  = tag_row[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign nkey = '0;
      assign ntg  = '0;
    end else begin : g_mid
      assign nkey = key_row[i+1];
      assign ntg  = tag_row[i+1];
    end
    sltn_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .index    (IDX_W'(i)),
      .ctl      (ctl),
      .prev_ge  (pge),
      .prev_key (pkey),
      .prev_tag (ptg),
      .next_key (nkey),
      .next_tag (ntg),
      .ge       (ge_row[i]),
      .key      (key_row[i]),
      .tag      (tag_row[i]),
      .sel_word (sel_row[i])
    );
  end

  for (genvar i = MAX_ENTRIES; i < NGRP * GRP_SIZE; i++) begin : g_pad
    assign sel_row[i] = '0;
  end

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    sltn_group u_group (
      .clk    (clk),
      .words  (sel_row[g*GRP_SIZE +: GRP_SIZE]),
      .merged (grp_row[g])
    );
  end

  always_comb begin
    top_acc = '0;
    for (int g = 0; g < NGRP; g++) begin
      top_acc = sel_word_t'(top_acc | grp_row[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd   <= s_axis_tuser;
      ln    <= s_axis_tdata[15:0];
      ptag  <= TAG_W'(s_axis_tdata[31:16]);
      empty <= s_axis_tdata[32];
      pos   <= s_axis_tdata[41:33];
    end
    if (state == S_RED) begin
      found <= top_acc;
    end
    if (fire) begin
      out_status <= out_status_next;
      out_index  <= out_index_next;
      out_line   <= out_line_next;
      out_tag    <= out_tag_next;
      out_count  <= OCNT_W'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        count <= count_next;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next      = state;
    op              = OP_NONE;
    count_next      = count;
    out_status_next = ST_INVALID;
    out_index_next  = '0;
    out_line_next   = '0;
    out_tag_next    = '0;

    case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = S_CMP;
        end
      end
      S_CMP: state_next = S_SEL;
      S_SEL: state_next = S_RED;
      S_RED: state_next = S_UPD;
      S_UPD: begin
        if (fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    case (cmd)
      CMD_STORE, CMD_DELETE: begin
        if (!ln_ok) begin
          out_status_next = ST_INVALID;
        end else if (cmd == CMD_DELETE || empty) begin
          if (found.hit) begin
            op              = OP_DELETE;
            count_next      = count - 1'b1;
            out_status_next = ST_DONE;
            out_index_next  = OIDX_W'(found.idx);
            out_line_next   = found.key;
            out_tag_next    = PTAG_W'(found.tag);
          end else begin
            out_status_next = ST_NOTFOUND;
          end
        end else if (found.hit) begin
          op              = OP_REPLACE;
          out_status_next = ST_REPLACED;
          out_index_next  = OIDX_W'(found.idx);
          out_line_next   = ln[KEY_W-1:0];
          out_tag_next    = PTAG_W'(ptag);
        end else if (count >= CNT_W'(MAX_ENTRIES)) begin
          out_status_next = ST_FULL;
        end else begin
          // With no match the first cell at or above the key is the slot.
          op              = OP_INSERT;
          count_next      = count + 1'b1;
          out_status_next = ST_INSERTED;
          out_index_next  = OIDX_W'(found.idx);
          out_line_next   = ln[KEY_W-1:0];
          out_tag_next    = PTAG_W'(ptag);
        end
      end
      CMD_FIND: begin
        if (!ln_ok) begin
          out_status_next = ST_INVALID;
        end else if (found.hit) begin
          out_status_next = ST_DONE;
          out_index_next  = OIDX_W'(found.idx);
          out_line_next   = found.key;
          out_tag_next    = PTAG_W'(found.tag);
        end else begin
          out_status_next = ST_NOTFOUND;
        end
      end
      CMD_READ: begin
        if ({{(CNT_W > POS_W ? CNT_W - POS_W : 0){1'b0}}, pos} < count) begin
          out_status_next = ST_DONE;
          out_index_next  = OIDX_W'(found.idx);
          out_line_next   = found.key;
          out_tag_next    = PTAG_W'(found.tag);
        end else begin
          out_status_next = ST_NOTFOUND;
        end
      end
      CMD_CLEAR: begin
        count_next      = '0;
        out_status_next = ST_DONE;
      end
      default: begin
        out_status_next = ST_INVALID;
      end
    endcase
  end

endmodule
